/* src/tlbp_pkg.sv */
// Shared constants and types for the two-level local-history branch predictor.
// No dependencies; imported by the request interface, the controller, the datapath, the top level and the testbench.
`default_nettype none

package tlbp_pkg;

    // Fixed geometry of the address split. Both counts are powers of two.
    localparam int HISTORY_ENTRIES  = 512;
    localparam int PATTERN_TABLES   = 8;
    localparam int HISTORY_BITS_DEF = 6;

    localparam int PC_W       = 32;
    localparam int TABLE_W    = $clog2(PATTERN_TABLES);
    localparam int HIST_IDX_W = $clog2(HISTORY_ENTRIES);
    localparam int PC_IDX_W   = TABLE_W + HIST_IDX_W;

    // Two-bit saturating counter.
    localparam int         CTR_W     = 2;
    localparam logic [1:0] CTR_MIN   = 2'd0;
    localparam logic [1:0] CTR_RESET = 2'd1;
    localparam logic [1:0] CTR_MAX   = 2'd3;

    // Request command codes.
    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_we;     // clearing pass writes both tables
        logic load_req;   // request accepted, history read issued
        logic load_hist;  // history data valid, counter read issued
        logic ctr_step;   // counter data valid, result and write-back
    } tlbp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;   // last entry of the clearing pass is being written
    } tlbp_status_t;

endpackage

`default_nettype wire

/* src/tlbp_req_if.sv */
// Request channel: valid/ready handshake carrying cmd, pc and taken.
// Depends on tlbp_pkg.
`default_nettype none

interface tlbp_req_if;
    import tlbp_pkg::*;

    logic            valid;
    logic            ready;
    logic            cmd;
    logic [PC_W-1:0] pc;
    logic            taken;

    modport source (output valid, output cmd, output pc, output taken, input ready);
    modport sink   (input valid, input cmd, input pc, input taken, output ready);
endinterface

`default_nettype wire

/* src/tlbp_rsp_if.sv */
// Result channel: valid/ready handshake carrying predict_taken.
// No dependencies.
`default_nettype none

interface tlbp_rsp_if;
    logic valid;
    logic ready;
    logic predict_taken;

    modport source (output valid, output predict_taken, input ready);
    modport sink   (input valid, input predict_taken, output ready);
endinterface

`default_nettype wire

/* src/tlbp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module tlbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

/* src/tlbp_ctrl.sv */
// Controller of the predictor: clearing pass, request sequencing and result valid.
// Depends on tlbp_pkg.
`default_nettype none

module tlbp_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_ready,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    output tlbp_pkg::tlbp_cmd_t         ctl,
    input  wire tlbp_pkg::tlbp_status_t sts
);
    import tlbp_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HIST,
        ST_CTR
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   rsp_free;
    logic   advance;
    logic   accept;

    // The result register can be loaded when empty or when it is being emptied.
    assign rsp_free  = !out_valid_reg || rsp_ready;
    assign advance   = (state_reg == ST_CTR) && rsp_free;
    assign req_ready = (state_reg == ST_IDLE) || advance;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = out_valid_reg;

    assign ctl.clr_we    = (state_reg == ST_CLEAR);
    assign ctl.load_req  = accept;
    assign ctl.load_hist = (state_reg == ST_HIST);
    assign ctl.ctr_step  = advance;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_HIST;
                end
            end
            ST_HIST:
            begin
                state_next = ST_CTR;
            end
            ST_CTR:
            begin
                if (advance)
                begin
                    state_next = accept ? ST_HIST : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A result only appears after the counter stage.
    a_rsp_from_ctr: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_CTR))
        else $error("result valid rose without a counter stage");

    // The history stage always hands over to the counter stage in the next cycle.
    a_hist_to_ctr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HIST |=> state_reg == ST_CTR)
        else $error("history stage did not advance");

    // No request is taken while the tables are being cleared.
    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clr_we |-> !ctl.load_req && !ctl.ctr_step)
        else $error("request activity during clearing pass");

    // Completing the counter stage always leaves a result waiting.
    a_step_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ctr_step |=> out_valid_reg)
        else $error("counter stage finished without a result");
endmodule

`default_nettype wire

/* src/tlbp_dp.sv */
// Datapath of the predictor: history and counter tables, update logic, result register.
// Depends on tlbp_pkg and tlbp_ram.
`default_nettype none

module tlbp_dp #(
    parameter int HISTORY_BITS = tlbp_pkg::HISTORY_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tlbp_pkg::tlbp_cmd_t           ctl,
    output tlbp_pkg::tlbp_status_t             sts,
    input  wire logic                          req_cmd,
    input  wire logic [tlbp_pkg::PC_IDX_W-1:0] req_pc_idx,
    input  wire logic                          req_taken,
    output logic                               predict_taken
);
    import tlbp_pkg::*;

    localparam int CTR_AW    = TABLE_W + HISTORY_BITS;
    localparam int CTR_DEPTH = 1 << CTR_AW;
    localparam int CLR_W     = (CTR_AW > HIST_IDX_W) ? CTR_AW : HIST_IDX_W;

    logic                    cmd_reg;
    logic                    taken_reg;
    logic [TABLE_W-1:0]      tbl_reg;
    logic [HIST_IDX_W-1:0]   hidx_reg;
    logic [CTR_AW-1:0]       cidx_reg;
    logic                    pred_reg;
    logic [CLR_W-1:0]        clr_cnt_reg, clr_cnt_next;

    logic [HISTORY_BITS-1:0] hist_rdata;
    logic [HISTORY_BITS:0]   hist_shift;
    logic [HISTORY_BITS-1:0] hist_upd;
    logic                    hist_we;
    logic [HIST_IDX_W-1:0]   hist_waddr;
    logic [HISTORY_BITS-1:0] hist_wdata;

    logic [CTR_W-1:0]        ctr_rdata;
    logic [CTR_W-1:0]        ctr_upd;
    logic [CTR_AW-1:0]       ctr_raddr;
    logic                    ctr_we;
    logic [CTR_AW-1:0]       ctr_waddr;
    logic [CTR_W-1:0]        ctr_wdata;

    // Outcome shifts in at the low end; the oldest bit drops off the top.
    assign hist_shift = {hist_rdata, taken_reg};
    assign hist_upd   = hist_shift[HISTORY_BITS-1:0];

    assign hist_we    = ctl.clr_we || (ctl.load_hist && (cmd_reg == CMD_UPDATE));
    assign hist_waddr = ctl.clr_we ? clr_cnt_reg[HIST_IDX_W-1:0] : hidx_reg;
    assign hist_wdata = ctl.clr_we ? '0 : hist_upd;

    assign ctr_raddr  = {tbl_reg, hist_rdata};

    always_comb
    begin
        if (taken_reg)
        begin
            ctr_upd = (ctr_rdata == CTR_MAX) ? ctr_rdata : ctr_rdata + 2'd1;
        end
        else
        begin
            ctr_upd = (ctr_rdata == CTR_MIN) ? ctr_rdata : ctr_rdata - 2'd1;
        end
    end

    assign ctr_we    = ctl.clr_we || (ctl.ctr_step && (cmd_reg == CMD_UPDATE));
    assign ctr_waddr = ctl.clr_we ? clr_cnt_reg[CTR_AW-1:0] : cidx_reg;
    assign ctr_wdata = ctl.clr_we ? CTR_RESET : ctr_upd;

    tlbp_ram #(
        .WIDTH (HISTORY_BITS),
        .DEPTH (HISTORY_ENTRIES)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (ctl.load_req),
        .raddr (req_pc_idx[PC_IDX_W-1:TABLE_W]),
        .rdata (hist_rdata)
    );

    tlbp_ram #(
        .WIDTH (CTR_W),
        .DEPTH (CTR_DEPTH)
    ) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (ctr_wdata),
        .re    (ctl.load_hist),
        .raddr (ctr_raddr),
        .rdata (ctr_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.load_req)
        begin
            cmd_reg   <= req_cmd;
            taken_reg <= req_taken;
            tbl_reg   <= req_pc_idx[TABLE_W-1:0];
            hidx_reg  <= req_pc_idx[PC_IDX_W-1:TABLE_W];
        end
        if (ctl.load_hist)
        begin
            cidx_reg <= ctr_raddr;
        end
        if (ctl.ctr_step)
        begin
            pred_reg <= ctr_rdata[1];
        end
    end

    assign clr_cnt_next = ctl.clr_we ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign sts.clr_done  = (clr_cnt_reg == '1);
    assign predict_taken = pred_reg;
endmodule

`default_nettype wire

/* src/two_level_local_branch_predictor_top.sv */
// Top level of the two-level local-history branch predictor.
// Depends on tlbp_pkg, tlbp_req_if, tlbp_rsp_if, tlbp_ctrl, tlbp_dp and tlbp_ram.
//
//  Channel | Direction | Handshake   | Payload
//  --------+-----------+-------------+---------------------------------
//  req     | in        | valid/ready | cmd (1), pc (32), taken (1)
//  rsp     | out       | valid/ready | predict_taken (1)
//
// The local history read comes first, and its data forms the address of the
// counter read, so the two chained table reads set the pace. When the result
// side keeps up, a new request is accepted in the cycle the previous one
// finishes. After reset the block clears both tables, stepping a counter of
// max(9, 3 + HISTORY_BITS) bits through every value, and accepts no request
// then. A stalled result waits in its own register. A request is still
// accepted while the block is idle, but it then holds in the counter stage,
// and no further request is accepted, until that register is free or is
// being emptied in the same cycle.
`default_nettype none

module two_level_local_branch_predictor_top #(
    parameter int HISTORY_BITS = tlbp_pkg::HISTORY_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tlbp_req_if.sink  req,
    tlbp_rsp_if.source rsp
);
    import tlbp_pkg::*;

    tlbp_cmd_t    ctl;
    tlbp_status_t sts;

    // The controller sequences the clearing pass and each request through
    // the history stage and the counter stage, and owns the result valid.
    tlbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    // Only the low address bits select a history entry and a pattern table;
    // the rest of the address does not reach the datapath.
    tlbp_dp #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .req_cmd       (req.cmd),
        .req_pc_idx    (req.pc[PC_IDX_W-1:0]),
        .req_taken     (req.taken),
        .predict_taken (rsp.predict_taken)
    );
endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the two-level local-history branch predictor.
// Depends on tlbp_pkg, tlbp_req_if, tlbp_rsp_if and two_level_local_branch_predictor_top.
// A scoreboard class mirrors the history and counter tables and checks every prediction.
`default_nettype none

module testbench;
    import tlbp_pkg::*;

    // The block is built with its default history length, and the mirror uses the same.
    localparam int HIST_W    = HISTORY_BITS_DEF;
    localparam int N_RANDOM  = 1150;
    localparam int HOT_COUNT = 16;

    // Mirror of the predictor state. Every accepted request pushes the prediction that
    // the block must return. Updates are then applied at once, because the block serves
    // requests strictly in order.
    class local_predictor_mirror;
        logic [HIST_W-1:0] history [HISTORY_ENTRIES];
        logic [CTR_W-1:0]  counters [PATTERN_TABLES][1 << HIST_W];
        bit                pending_predictions [$];
        int                mismatches;
        int                n_predicts;
        int                n_updates;
        int                n_checked;
        int                n_taken_seen;

        function new();
            foreach (history[i])
                history[i] = '0;
            foreach (counters[t, h])
                counters[t][h] = CTR_RESET;
        endfunction

        function void note_request(logic cmd, logic [PC_W-1:0] pc, logic taken);
            logic [TABLE_W-1:0]    tbl;
            logic [HIST_IDX_W-1:0] slot;
            logic [HIST_W-1:0]     hist;
            logic [CTR_W-1:0]      ctr;
            tbl  = pc[TABLE_W-1:0];
            slot = pc[PC_IDX_W-1:TABLE_W];
            hist = history[slot];
            ctr  = counters[tbl][hist];
            pending_predictions.push_back(ctr >= 2'd2);
            if (cmd == CMD_UPDATE)
            begin
                n_updates++;
                if (taken && ctr != CTR_MAX)
                    ctr++;
                else if (!taken && ctr != CTR_MIN)
                    ctr--;
                counters[tbl][hist] = ctr;
                history[slot] = {hist[HIST_W-2:0], taken};
            end
            else
            begin
                n_predicts++;
            end
        endfunction

        function void check_prediction(logic actual);
            bit expected;
            if (pending_predictions.size() == 0)
            begin
                $error("predict_taken: no result expected, actual %0b", actual);
                mismatches++;
                return;
            end
            expected = pending_predictions.pop_front();
            n_checked++;
            if (actual === 1'b1)
                n_taken_seen++;
            if (actual !== expected)
            begin
                $error("predict_taken: expected %0b, actual %0b", expected, actual);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tlbp_req_if req_ch();
    tlbp_rsp_if rsp_ch();

    two_level_local_branch_predictor_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    local_predictor_mirror mirror = new();

    // While a side is steady it never idles, so back-to-back requests and results
    // also occur. Each side flips its mode now and then.
    bit req_steady;
    bit rsp_steady;

    // Random part: most traffic goes to a small set of hot branches. Their low address
    // bits are fixed and their directions follow loop-like patterns, so that local
    // histories fill up and counters walk across their whole range. The remaining
    // traffic uses fully random addresses and commands.
    logic [11:0] hot_low    [HOT_COUNT];
    int          hot_period [HOT_COUNT];
    int          hot_count  [HOT_COUNT];

    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    // Presents one request after a random pause and waits until it is accepted. The
    // valid is lowered only when a pause follows, so a back-to-back request keeps it high.
    task automatic send_request(input logic cmd, input logic [PC_W-1:0] pc, input logic taken);
        int gap;
        if ($urandom_range(0, 39) == 0)
            req_steady = !req_steady;
        gap = req_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= cmd;
        req_ch.pc    <= pc;
        req_ch.taken <= taken;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        mirror.note_request(cmd, pc, taken);
    endtask

    // Result side: stalls for a random number of cycles, then takes one result and
    // hands it to the scoreboard. The ready is lowered only when a stall follows.
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rsp_steady = !rsp_steady;
            stall = rsp_steady ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            mirror.check_prediction(rsp_ch.predict_taken);
        end
    end

    // Main sequence: reset, directed requests, random requests, then drain.
    initial
    begin
        int              sel;
        int              slot;
        logic            cmd;
        logic            taken;
        logic [PC_W-1:0] pc;

        req_ch.valid <= 1'b0;
        req_ch.cmd   <= CMD_PREDICT;
        req_ch.pc    <= '0;
        req_ch.taken <= 1'b0;
        rst_n        <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Predicts at both address extremes. The second one also carries taken high,
        // which must be ignored and must leave the state untouched.
        send_request(CMD_PREDICT, 32'h0000_0000, 1'b0);
        send_request(CMD_PREDICT, 32'hFFFF_FFFF, 1'b1);

        // Nine taken updates on one branch. After six of them the history is all ones,
        // and the last three drive that counter to its upper limit and hold it there.
        repeat (9)
            send_request(CMD_UPDATE, 32'h0000_05A3, 1'b1);
        // The same branch seen through different upper address bits must give the
        // same taken prediction.
        send_request(CMD_PREDICT, 32'hFFFF_F5A3, 1'b0);

        // Two not-taken updates on a fresh branch with its history at zero. The second
        // one hits the lower counter limit. The upper address bits differ on purpose.
        send_request(CMD_UPDATE, 32'h8000_0A5C, 1'b0);
        send_request(CMD_UPDATE, 32'h1234_5A5C, 1'b0);
        send_request(CMD_PREDICT, 32'h0000_0A5C, 1'b1);

        // Step the saturated counter back down, then touch every pattern table once.
        send_request(CMD_UPDATE, 32'h0000_05A3, 1'b0);
        for (int i = 0; i < PATTERN_TABLES; i++)
            send_request(CMD_UPDATE, 32'h0000_0FF8 + i, i[0]);

        for (int i = 0; i < HOT_COUNT; i++)
        begin
            hot_low[i]    = 12'($urandom_range(0, 4095));
            hot_period[i] = $urandom_range(1, 8);
            hot_count[i]  = 0;
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 80)
            begin
                slot  = $urandom_range(0, HOT_COUNT - 1);
                pc    = {20'($urandom_range(0, 20'hFFFFF)), hot_low[slot]};
                cmd   = ($urandom_range(0, 3) != 0) ? CMD_UPDATE : CMD_PREDICT;
                taken = 1'($urandom_range(0, 1));
                if (cmd == CMD_UPDATE)
                begin
                    // Loop-like branch: taken except on the last pass of each period,
                    // with an occasional random flip to disturb the pattern.
                    taken = (hot_count[slot] % hot_period[slot]) != hot_period[slot] - 1;
                    if ($urandom_range(0, 15) == 0)
                        taken = !taken;
                    hot_count[slot]++;
                end
            end
            else
            begin
                pc    = $urandom();
                cmd   = $urandom_range(0, 1) ? CMD_UPDATE : CMD_PREDICT;
                taken = 1'($urandom_range(0, 1));
            end
            send_request(cmd, pc, taken);
        end
        req_ch.valid <= 1'b0;

        // Wait for every outstanding result, then wait longer to catch any
        // spurious extra result.
        while (mirror.pending_predictions.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run covered %0d predict and %0d update requests.",
                 mirror.n_predicts, mirror.n_updates);
        $display("%0d results were checked, %0d of them predicted taken.",
                 mirror.n_checked, mirror.n_taken_seen);
        if (mirror.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, including the table clearing
    // pass after reset and the longest pauses on both sides.
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
